/* rtl/core/nrf_pkg.sv */
// shared constants, command struct and arctangent table for the nearest return finder
package nrf_pkg;

    localparam int RANGE_W     = 16;
    localparam int IDX_OUT_W   = 11;
    localparam int POS_W       = 17;
    localparam int ANGLE_W     = 16;
    localparam int ASTEP_W     = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int VEC_W       = 35;
    localparam int Z_W         = 26;
    localparam int STEP_W      = 5;

    localparam int DEF_MAX_BEAMS    = 2048;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam logic [RANGE_W-1:0] GAIN_Q16   = 16'd39796;
    localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 16'd500;
    localparam logic [ANGLE_W-1:0] START_RST  = 16'hC000;
    localparam logic [ASTEP_W-1:0] ASTEP_RST  = 12'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 2'd2;

    typedef struct packed {
        logic              sample;
        logic              prep;
        logic              rotate;
        logic              load_out;
        logic [STEP_W-1:0] step;
    } t_cmd;

    // atan(2^-i) in 1/2^24 turn units, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_val(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            5'd0:  v = 26'sd2097152;
            5'd1:  v = 26'sd1238021;
            5'd2:  v = 26'sd654136;
            5'd3:  v = 26'sd332050;
            5'd4:  v = 26'sd166669;
            5'd5:  v = 26'sd83416;
            5'd6:  v = 26'sd41718;
            5'd7:  v = 26'sd20860;
            5'd8:  v = 26'sd10430;
            5'd9:  v = 26'sd5215;
            5'd10: v = 26'sd2608;
            5'd11: v = 26'sd1304;
            5'd12: v = 26'sd652;
            5'd13: v = 26'sd326;
            5'd14: v = 26'sd163;
            5'd15: v = 26'sd81;
            5'd16: v = 26'sd41;
            5'd17: v = 26'sd20;
            5'd18: v = 26'sd10;
            5'd19: v = 26'sd5;
            5'd20: v = 26'sd3;
            5'd21: v = 26'sd1;
            5'd22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/nrf_sample_if.sv */
// range sample channel
interface nrf_sample_if;
    logic                        valid;
    logic                        ready;
    logic [nrf_pkg::RANGE_W-1:0] range_mm;
    logic                        last_in_scan;

    modport source (output valid, output range_mm, output last_in_scan, input ready);
    modport sink   (input valid, input range_mm, input last_in_scan, output ready);
endinterface

/* rtl/core/nrf_result_if.sv */
// scan result channel
interface nrf_result_if;
    logic                                valid;
    logic                                ready;
    logic                                person_seen;
    logic [nrf_pkg::IDX_OUT_W-1:0]       nearest_index;
    logic [nrf_pkg::RANGE_W-1:0]         nearest_range;
    logic signed [nrf_pkg::POS_W-1:0]    x_mm;
    logic signed [nrf_pkg::POS_W-1:0]    y_mm;

    modport source (output valid, output person_seen, output nearest_index,
                    output nearest_range, output x_mm, output y_mm, input ready);
    modport sink   (input valid, input person_seen, input nearest_index,
                    input nearest_range, input x_mm, input y_mm, output ready);
endinterface

/* rtl/core/nrf_ctrl.sv */
// controller: scan intake, cordic sequencing and result handoff
module nrf_ctrl #(
    parameter int CORDIC_STEPS = nrf_pkg::DEF_CORDIC_STEPS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output nrf_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_SCAN = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_ROT  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [nrf_pkg::STEP_W-1:0] LAST_STEP = nrf_pkg::STEP_W'(CORDIC_STEPS - 1);

    logic [1:0]                   r_state, n_state;
    logic [nrf_pkg::STEP_W-1:0]   r_step, n_step;
    logic                         r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd          = '0;
        o_cmd.step     = r_step;
        unique case (r_state)
            S_SCAN: begin
                if (i_in_valid) begin
                    o_cmd.sample = 1'b1;
                    if (i_in_last) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_step     = '0;
                n_state    = S_ROT;
            end
            S_ROT: begin
                o_cmd.rotate = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_SCAN;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SCAN;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_SCAN);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/nrf_dp.sv */
// datapath: config registers, nearest tracking, shared cordic rotator, result register
module nrf_dp #(
    parameter int MAX_BEAMS = nrf_pkg::DEF_MAX_BEAMS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [nrf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [nrf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  nrf_pkg::t_cmd                        i_cmd,
    input  logic [nrf_pkg::RANGE_W-1:0]          i_range_mm,
    output logic                                 o_person_seen,
    output logic [nrf_pkg::IDX_OUT_W-1:0]        o_nearest_index,
    output logic [nrf_pkg::RANGE_W-1:0]          o_nearest_range,
    output logic signed [nrf_pkg::POS_W-1:0]     o_x_mm,
    output logic signed [nrf_pkg::POS_W-1:0]     o_y_mm
);

    localparam int IW = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
    localparam int CW = $clog2(MAX_BEAMS + 1);
    localparam int PW = IW + nrf_pkg::ASTEP_W + nrf_pkg::ANGLE_W;
    localparam int VW = nrf_pkg::VEC_W;
    localparam int ZW = nrf_pkg::Z_W;
    localparam int OW = nrf_pkg::POS_W;

    // config
    logic [nrf_pkg::RANGE_W-1:0] r_min_range;
    logic [nrf_pkg::ANGLE_W-1:0] r_start;
    logic [nrf_pkg::ASTEP_W-1:0] r_astep;

    // scan tracking
    logic [nrf_pkg::RANGE_W-1:0] r_best_range;
    logic [IW-1:0]               r_best_idx;
    logic                        r_have;
    logic [CW-1:0]               r_cnt;
    logic                        in_window;
    logic                        take;

    // captured scan result
    logic                        r_seen;
    logic [nrf_pkg::RANGE_W-1:0] r_res_range;
    logic [IW-1:0]               r_res_idx;

    // rotator
    logic signed [VW-1:0]        r_x, r_y;
    logic signed [ZW-1:0]        r_z;
    logic                        r_flip;
    logic [PW-1:0]               ang_prod;
    logic [nrf_pkg::ANGLE_W-1:0] ang;
    logic signed [nrf_pkg::ANGLE_W-1:0] s_raw, s_adj;
    logic                        flip0;
    logic [31:0]                 x_prod;
    logic signed [VW-1:0]        dx, dy;
    logic signed [ZW-1:0]        atan_i;
    logic signed [VW-1:0]        xf, yf;
    logic [IW+nrf_pkg::IDX_OUT_W-1:0] idx_ext;

    // output register
    logic                        r_o_seen;
    logic [nrf_pkg::IDX_OUT_W-1:0] r_o_idx;
    logic [nrf_pkg::RANGE_W-1:0] r_o_range;
    logic signed [OW-1:0]        r_o_x, r_o_y;

    // round to mm and clamp to the 17-bit symmetric range
    function automatic logic signed [OW-1:0] round_sat(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] t;
        t = (v + VW'(32768)) >>> 16;
        if (t > VW'(65535)) begin
            t = VW'(65535);
        end else if (t < -VW'(65535)) begin
            t = -VW'(65535);
        end
        return t[OW-1:0];
    endfunction

    assign in_window = (r_cnt != CW'(MAX_BEAMS));
    assign take = i_cmd.sample && in_window && (i_range_mm > r_min_range)
                  && (!r_have || (i_range_mm < r_best_range));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range <= nrf_pkg::MIN_RANGE_RST;
            r_start     <= nrf_pkg::START_RST;
            r_astep     <= nrf_pkg::ASTEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nrf_pkg::CFG_MIN_RANGE:  r_min_range <= i_cfg_data;
                nrf_pkg::CFG_START:      r_start     <= i_cfg_data;
                nrf_pkg::CFG_ANGLE_STEP: r_astep     <= i_cfg_data[nrf_pkg::ASTEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_range <= '0;
            r_best_idx   <= '0;
            r_have       <= 1'b0;
            r_cnt        <= '0;
        end else if (i_cmd.prep) begin
            r_best_range <= '0;
            r_best_idx   <= '0;
            r_have       <= 1'b0;
            r_cnt        <= '0;
        end else if (i_cmd.sample && in_window) begin
            r_cnt <= r_cnt + 1'b1;
            if (take) begin
                r_best_range <= i_range_mm;
                r_best_idx   <= r_cnt[IW-1:0];
                r_have       <= 1'b1;
            end
        end
    end

    // beam angle, folded into the right half plane
    assign ang_prod = PW'(r_best_idx) * PW'(r_astep);
    assign ang      = r_start + ang_prod[nrf_pkg::ANGLE_W-1:0];
    assign s_raw    = signed'(ang);
    always_comb begin
        s_adj = s_raw;
        flip0 = 1'b0;
        if (s_raw > 16'sd16384) begin
            s_adj = s_raw - 16'sd32767 - 16'sd1;
            flip0 = 1'b1;
        end else if (s_raw < -16'sd16384) begin
            s_adj = s_raw + 16'sd32767 + 16'sd1;
            flip0 = 1'b1;
        end
    end
    assign x_prod = r_best_range * nrf_pkg::GAIN_Q16;

    assign dx     = r_y >>> i_cmd.step;
    assign dy     = r_x >>> i_cmd.step;
    assign atan_i = nrf_pkg::atan_val(i_cmd.step);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_seen      <= r_have;
            r_res_range <= r_best_range;
            r_res_idx   <= r_best_idx;
            r_x         <= signed'({3'b000, x_prod});
            r_y         <= '0;
            r_z         <= {{2{s_adj[15]}}, s_adj, 8'h00};
            r_flip      <= flip0;
        end else if (i_cmd.rotate) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_i;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_i;
            end
        end
    end

    assign xf      = r_flip ? -r_x : r_x;
    assign yf      = r_flip ? -r_y : r_y;
    assign idx_ext = {{nrf_pkg::IDX_OUT_W{1'b0}}, r_res_idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_seen <= r_seen;
            if (r_seen) begin
                r_o_idx   <= idx_ext[nrf_pkg::IDX_OUT_W-1:0];
                r_o_range <= r_res_range;
                r_o_x     <= round_sat(xf);
                r_o_y     <= round_sat(yf);
            end else begin
                r_o_idx   <= '0;
                r_o_range <= '0;
                r_o_x     <= '0;
                r_o_y     <= '0;
            end
        end
    end

    assign o_person_seen   = r_o_seen;
    assign o_nearest_index = r_o_idx;
    assign o_nearest_range = r_o_range;
    assign o_x_mm          = r_o_x;
    assign o_y_mm          = r_o_y;

endmodule

/* rtl/core/nearest_return_finder.sv */
// top level of the nearest lidar return finder
// Range samples are taken one per cycle while a scan streams. The request that
// carries last_in_scan closes the scan; the block then forms the beam angle in
// the prep state, runs CORDIC_STEPS iterations of its single shared CORDIC
// rotator and loads the result register, and sample input is held off from each
// closing sample until that load (longer while an earlier result still waits in
// the result register). Samples past MAX_BEAMS in a scan
// are counted out and ignored. Configuration writes take effect on the next cycle.
module nearest_return_finder #(
    parameter int MAX_BEAMS    = nrf_pkg::DEF_MAX_BEAMS,
    parameter int CORDIC_STEPS = nrf_pkg::DEF_CORDIC_STEPS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nrf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nrf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    nrf_sample_if.sink                     i_sample,
    nrf_result_if.source                   o_result
);

    nrf_pkg::t_cmd cmd;

    nrf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .i_in_last   (i_sample.last_in_scan),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    nrf_dp #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .i_range_mm      (i_sample.range_mm),
        .o_person_seen   (o_result.person_seen),
        .o_nearest_index (o_result.nearest_index),
        .o_nearest_range (o_result.nearest_range),
        .o_x_mm          (o_result.x_mm),
        .o_y_mm          (o_result.y_mm)
    );

endmodule
